@@ rtl/core/mlb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_pkg: shared types and constants of the LED blink controller
// Table size, counter width, operation codes, the per-channel state type and the command type.
// ----------------------------------------------------------------------------
package mlb_pkg;

   localparam int unsigned LED_COUNT  = 8;
   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned CH_BITS    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int unsigned RESULT_CAP = 8;
   localparam int unsigned N_REPORT   = (LED_COUNT < RESULT_CAP) ? LED_COUNT : RESULT_CAP;

   localparam logic [15:0] FOREVER_BUDGET = 16'hFFFF;
   localparam logic [15:0] PERIOD_LIMIT   = (COUNT_BITS < 16) ?
      16'((32'd1 << COUNT_BITS) - 32'd1) : 16'hFFFF;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   typedef struct packed {
      logic                  registered;
      logic                  active;
      logic [COUNT_BITS-1:0] period;
      logic [COUNT_BITS-1:0] countdown;
      logic [15:0]           budget;
      logic                  final_level;
      logic                  phase;
      logic                  level;
   } chan_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] blink_period;
      logic [15:0] toggle_budget;
      logic        level_arg;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/core/mlb_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_req_if: request channel of the LED blink controller
// Valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface mlb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [2:0]  led_index;
   logic [15:0] blink_period;
   logic [15:0] toggle_budget;
   logic        level_arg;

   modport source (output valid, operation, led_index, blink_period, toggle_budget,
                   level_arg, input ready);
   modport sink (input valid, operation, led_index, blink_period, toggle_budget,
                 level_arg, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mlb_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_rsp_if: response channel of the LED blink controller
// Valid/ready handshake carrying one channel status word.
// ----------------------------------------------------------------------------
interface mlb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_index;
   logic       led_level;
   logic       is_registered;
   logic       is_blinking;
   logic       last_result;

   modport source (output valid, out_index, led_level, is_registered, is_blinking,
                   last_result, input ready);
   modport sink (input valid, out_index, led_level, is_registered, is_blinking,
                 last_result, output ready);
endinterface
`default_nettype wire

@@ rtl/core/multi_led_blink_controller_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_led_blink_controller_unit: table of LED blink channels
// A sequencer walks the channel table through one shared update unit.
// ----------------------------------------------------------------------------
// A tick walks the LED_COUNT table entries (8 here) one per cycle, unless the
// result port stalls, through the shared channel update unit and emits one word
// per reported channel; a new command is taken only once the walk is back in idle.
// Add, start and stop give one word each, after which the unit returns to idle.
// A stalled result port holds the walk. Reset clears all flags, periods,
// countdowns, phases and levels; budgets and final levels are not reset.
// ----------------------------------------------------------------------------
module multi_led_blink_controller_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   mlb_req_if.sink    req_ch,
   mlb_rsp_if.source  rsp_ch
);
   import mlb_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TICK = 2'd1;
   localparam logic [1:0] S_CMD  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CH_BITS-1:0]   ch_ff, ch_in;
   cmd_type              cmd_ff;
   logic [2:0]           idx_ff;

   logic [LED_COUNT-1:0] registered_ff, active_ff, phase_ff, level_ff;
   logic [COUNT_BITS-1:0] period_ff    [LED_COUNT];
   logic [COUNT_BITS-1:0] countdown_ff [LED_COUNT];
   logic [15:0]           budget_ff    [LED_COUNT];
   logic [LED_COUNT-1:0]  final_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_index_ff;
   logic       rsp_level_ff, rsp_reg_ff, rsp_blink_ff, rsp_last_ff;

   logic [CH_BITS-1:0] addr;
   logic               in_table;
   logic               slot_free;
   logic               emit;
   logic               step;
   logic               write_en;
   logic               walk_done;
   cmd_type            unit_cmd;
   chan_type           cur;
   chan_type           nxt;

   assign in_table  = 32'(idx_ff) < LED_COUNT;
   assign addr      = (state_ff == S_TICK) ? ch_ff : CH_BITS'(idx_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit      = (state_ff == S_TICK) ? (32'(ch_ff) < N_REPORT) : 1'b1;
   assign step      = (state_ff != S_IDLE) && (!emit || slot_free);
   assign walk_done = ch_ff == CH_BITS'(LED_COUNT - 1);
   assign write_en  = step && ((state_ff == S_TICK) || in_table);

   always_comb begin
      unit_cmd           = cmd_ff;
      if (state_ff == S_TICK) begin
         unit_cmd.operation = OP_TICK;
      end
      cur.registered  = registered_ff[addr];
      cur.active      = active_ff[addr];
      cur.period      = period_ff[addr];
      cur.countdown   = countdown_ff[addr];
      cur.budget      = budget_ff[addr];
      cur.final_level = final_ff[addr];
      cur.phase       = phase_ff[addr];
      cur.level       = level_ff[addr];
   end

   mlb_chan_unit u_chan (
      .cmd (unit_cmd),
      .cur (cur),
      .nxt (nxt)
   );

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = (req_ch.operation == OP_TICK) ? S_TICK : S_CMD;
               ch_in    = '0;
            end
         end
         S_TICK: begin
            if (step) begin
               if (walk_done) begin
                  state_in = S_IDLE;
                  ch_in    = '0;
               end else begin
                  ch_in = ch_ff + CH_BITS'(1);
               end
            end
         end
         S_CMD: begin
            if (step) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff.operation     <= req_ch.operation;
         cmd_ff.blink_period  <= req_ch.blink_period;
         cmd_ff.toggle_budget <= req_ch.toggle_budget;
         cmd_ff.level_arg     <= req_ch.level_arg;
         idx_ff               <= req_ch.led_index;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         if (state_ff == S_TICK) begin
            rsp_index_ff <= 3'(ch_ff);
            rsp_level_ff <= nxt.level;
            rsp_reg_ff   <= nxt.registered;
            rsp_blink_ff <= nxt.active;
            rsp_last_ff  <= 32'(ch_ff) == N_REPORT - 1;
         end else begin
            rsp_index_ff <= idx_ff;
            rsp_level_ff <= in_table & nxt.level;
            rsp_reg_ff   <= in_table & nxt.registered;
            rsp_blink_ff <= in_table & nxt.active;
            rsp_last_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         active_ff     <= '0;
         phase_ff      <= '0;
         level_ff      <= '0;
         for (int i = 0; i < LED_COUNT; i++) begin
            period_ff[i]    <= '0;
            countdown_ff[i] <= '0;
         end
      end else if (write_en) begin
         registered_ff[addr] <= nxt.registered;
         active_ff[addr]     <= nxt.active;
         phase_ff[addr]      <= nxt.phase;
         level_ff[addr]      <= nxt.level;
         period_ff[addr]     <= nxt.period;
         countdown_ff[addr]  <= nxt.countdown;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         budget_ff[addr] <= nxt.budget;
         final_ff[addr]  <= nxt.final_level;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_index     = rsp_index_ff;
   assign rsp_ch.led_level     = rsp_level_ff;
   assign rsp_ch.is_registered = rsp_reg_ff;
   assign rsp_ch.is_blinking   = rsp_blink_ff;
   assign rsp_ch.last_result   = rsp_last_ff;

   // A channel can only blink after it has been added.
   a_active_registered: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~registered_ff) == '0)
      else $error("active channel that was never added");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TICK |-> 32'(ch_ff) < LED_COUNT)
      else $error("tick walk index out of table");

   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMD && step) |=> (state_ff == S_IDLE && rsp_ch.valid && rsp_ch.last_result))
      else $error("command did not finish with one final word");

   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK && step && emit && 32'(ch_ff) == N_REPORT - 1)
      |=> rsp_ch.last_result)
      else $error("last reported channel of a tick not marked final");

endmodule
`default_nettype wire

@@ rtl/core/mlb_chan_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_chan_unit: shared channel update unit
// Computes the next state of one channel for a tick, add, start or stop.
// ----------------------------------------------------------------------------
module mlb_chan_unit (
   input  mlb_pkg::cmd_type  cmd,
   input  mlb_pkg::chan_type cur,
   output mlb_pkg::chan_type nxt
);
   import mlb_pkg::*;

   logic [COUNT_BITS-1:0] cnt_eff;
   logic [COUNT_BITS-1:0] cnt_dec;
   logic [15:0]           sat_period;
   logic                  new_phase;

   assign cnt_eff    = (cur.countdown == '0) ? COUNT_BITS'(1) : cur.countdown;
   assign cnt_dec    = cnt_eff - COUNT_BITS'(1);
   assign sat_period = (cmd.blink_period > PERIOD_LIMIT) ? PERIOD_LIMIT : cmd.blink_period;
   assign new_phase  = ~cur.phase;

   always_comb begin
      nxt = cur;
      unique case (cmd.operation)
         OP_TICK: begin
            if (cur.active && cur.period != '0) begin
               if (cnt_dec != '0) begin
                  nxt.countdown = cnt_dec;
               end else begin
                  nxt.countdown = cur.period;
                  nxt.phase     = new_phase;
                  nxt.level     = new_phase;
                  if (cur.budget != FOREVER_BUDGET) begin
                     if (cur.budget <= 16'd1) begin
                        nxt.active    = 1'b0;
                        nxt.period    = '0;
                        nxt.countdown = '0;
                        nxt.level     = cur.final_level;
                     end else begin
                        nxt.budget = cur.budget - 16'd1;
                     end
                  end
               end
            end
         end
         OP_ADD: begin
            nxt.registered = 1'b1;
            nxt.active     = 1'b0;
            nxt.period     = '0;
            nxt.countdown  = '0;
            nxt.phase      = cmd.level_arg;
            nxt.level      = cmd.level_arg;
         end
         OP_START: begin
            if (cur.registered) begin
               nxt.active      = 1'b1;
               nxt.period      = COUNT_BITS'(sat_period);
               nxt.countdown   = COUNT_BITS'(sat_period);
               nxt.budget      = cmd.toggle_budget;
               nxt.final_level = cmd.level_arg;
               nxt.phase       = 1'b1;
               nxt.level       = 1'b1;
            end
         end
         OP_STOP: begin
            if (cur.registered) begin
               nxt.active    = 1'b0;
               nxt.period    = '0;
               nxt.countdown = '0;
               nxt.level     = cmd.level_arg;
            end
         end
         default: nxt = cur;
      endcase
   end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the LED blink controller unit
// Directed commands, then random ones with mostly valid content. Status words are
// checked against a bench model of the channel table, or for typed rows against
// the row's fields. Both handshakes are throttled at random outside a calm stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import mlb_pkg::*;

   localparam int N_DIRECTED  = 25;
   localparam int N_RANDOM    = 480;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  idx;
      logic [15:0] period;
      logic [15:0] budget;
      logic        level;
      logic        typed;
      logic        t_level;
      logic        t_reg;
      logic        t_blink;
   } stim_row_type;

   typedef struct packed {
      logic [2:0] index;
      logic       level;
      logic       registered;
      logic       blinking;
      logic       last;
   } status_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlb_req_if req_bus ();
   mlb_rsp_if rsp_bus ();

   multi_led_blink_controller_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   logic        chan_registered [LED_COUNT];
   logic        chan_active     [LED_COUNT];
   logic [15:0] chan_period     [LED_COUNT];
   logic [15:0] chan_count      [LED_COUNT];
   logic [15:0] chan_budget     [LED_COUNT];
   logic        chan_final      [LED_COUNT];
   logic        chan_phase      [LED_COUNT];
   logic        chan_level      [LED_COUNT];

   status_word_type due_status [N_REPORT];
   int              due_count;
   status_word_type pending_status [$];

   int failures      = 0;
   int words_checked = 0;
   int commands_sent = 0;
   int ticks_sent    = 0;
   int toggles_seen  = 0;
   int auto_stops    = 0;
   int cycle_count   = 0;
   bit calm          = 1'b0;

   stim_row_type directed [N_DIRECTED] = '{
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_START, 3'd3, 16'd5,     16'd5,     1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_STOP,  3'd5, 16'd0,     16'd0,     1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_ADD,   3'd0, 16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{OP_ADD,   3'd7, 16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
      '{OP_START, 3'd0, 16'd1,     16'd2,     1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,  3'd7, 16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_START, 3'd7, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_STOP,  3'd7, 16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{OP_ADD,   3'd2, 16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{OP_START, 3'd2, 16'd0,     16'd5,     1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_ADD,   3'd2, 16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
      '{OP_ADD,   3'd4, 16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{OP_START, 3'd4, 16'd2,     16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_ADD,   3'd1, 16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
      '{OP_START, 3'd1, 16'd1,     16'hFFFF,  1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,  3'd0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_STOP,  3'd1, 16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
      '{OP_START, 3'd6, 16'd3,     16'hFFFE,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
   };

   task automatic halt_channel(int ch, logic level);
      chan_active[ch] = 1'b0;
      chan_period[ch] = '0;
      chan_count[ch]  = '0;
      chan_level[ch]  = level;
   endtask

   task automatic advance_channel(int ch);
      logic [15:0] remaining;
      if (!chan_active[ch] || chan_period[ch] == 16'd0) begin
         return;
      end
      remaining = (chan_count[ch] == 16'd0) ? 16'd1 : chan_count[ch];
      remaining = remaining - 16'd1;
      chan_count[ch] = remaining;
      if (remaining != 16'd0) begin
         return;
      end
      chan_count[ch] = chan_period[ch];
      chan_phase[ch] = ~chan_phase[ch];
      chan_level[ch] = chan_phase[ch];
      toggles_seen++;
      if (chan_budget[ch] != FOREVER_BUDGET) begin
         if (chan_budget[ch] <= 16'd1) begin
            halt_channel(ch, chan_final[ch]);
            auto_stops++;
         end else begin
            chan_budget[ch] = chan_budget[ch] - 16'd1;
         end
      end
   endtask

   task automatic apply_command(stim_row_type c);
      int ch;
      if (c.op == OP_TICK) begin
         for (ch = 0; ch < LED_COUNT; ch++) begin
            advance_channel(ch);
         end
         for (ch = 0; ch < N_REPORT; ch++) begin
            due_status[ch] = '{3'(ch), chan_level[ch], chan_registered[ch],
                               chan_active[ch], ch == N_REPORT - 1};
         end
         due_count = N_REPORT;
      end else begin
         ch = int'(c.idx);
         if (c.op == OP_ADD) begin
            chan_registered[ch] = 1'b1;
            chan_active[ch]     = 1'b0;
            chan_period[ch]     = '0;
            chan_count[ch]      = '0;
            chan_phase[ch]      = c.level;
            chan_level[ch]      = c.level;
         end else if (chan_registered[ch]) begin
            if (c.op == OP_START) begin
               chan_active[ch] = 1'b1;
               chan_period[ch] = (c.period > PERIOD_LIMIT) ? PERIOD_LIMIT : c.period;
               chan_count[ch]  = chan_period[ch];
               chan_budget[ch] = c.budget;
               chan_final[ch]  = c.level;
               chan_phase[ch]  = 1'b1;
               chan_level[ch]  = 1'b1;
            end else begin
               halt_channel(ch, c.level);
            end
         end
         due_status[0] = '{c.idx, chan_level[ch], chan_registered[ch], chan_active[ch], 1'b1};
         due_count = 1;
      end
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      int pick;
      r = '0;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.op = OP_TICK;
      end else if (pick < 55) begin
         r.op = OP_ADD;
      end else if (pick < 85) begin
         r.op = OP_START;
      end else begin
         r.op = OP_STOP;
      end
      r.idx   = 3'($urandom_range(0, LED_COUNT - 1));
      r.level = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.period = 16'd0;
      end else if (pick < 70) begin
         r.period = 16'($urandom_range(1, 4));
      end else if (pick < 85) begin
         r.period = 16'($urandom_range(5, 40));
      end else begin
         r.period = 16'($urandom_range(0, 16'hFFFF));
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         r.budget = 16'($urandom_range(0, 4));
      end else if (pick < 55) begin
         r.budget = FOREVER_BUDGET;
      end else begin
         r.budget = 16'($urandom_range(0, 16'hFFFF));
      end
      return r;
   endfunction

   task automatic send_command(stim_row_type r);
      int k;
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= r.op;
      req_bus.led_index     <= r.idx;
      req_bus.blink_period  <= r.period;
      req_bus.toggle_budget <= r.budget;
      req_bus.level_arg     <= r.level;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      apply_command(r);
      for (k = 0; k < due_count; k++) begin
         if (r.typed) begin
            due_status[k].level      = r.t_level;
            due_status[k].registered = r.t_reg;
            due_status[k].blinking   = r.t_blink;
         end
         pending_status.push_back(due_status[k]);
      end
      commands_sent++;
      if (r.op == OP_TICK) begin
         ticks_sent++;
      end
      if (!calm && $urandom_range(0, 99) < 26) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 26);
   end

   always @(posedge clock) begin
      status_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_status.size() == 0) begin
            $error("status word for channel %0d arrived with none outstanding",
                   rsp_bus.out_index);
            failures++;
         end else begin
            want = pending_status.pop_front();
            check_field("out_index", int'(want.index), int'(rsp_bus.out_index));
            check_field("led_level", int'(want.level), int'(rsp_bus.led_level));
            check_field("is_registered", int'(want.registered),
                        int'(rsp_bus.is_registered));
            check_field("is_blinking", int'(want.blinking), int'(rsp_bus.is_blinking));
            check_field("last_result", int'(want.last), int'(rsp_bus.last_result));
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int i;
      req_bus.valid         = 1'b0;
      req_bus.operation     = OP_TICK;
      req_bus.led_index     = '0;
      req_bus.blink_period  = '0;
      req_bus.toggle_budget = '0;
      req_bus.level_arg     = 1'b0;
      for (i = 0; i < LED_COUNT; i++) begin
         chan_registered[i] = 1'b0;
         chan_active[i]     = 1'b0;
         chan_period[i]     = '0;
         chan_count[i]      = '0;
         chan_budget[i]     = '0;
         chan_final[i]      = 1'b0;
         chan_phase[i]      = 1'b0;
         chan_level[i]      = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < N_DIRECTED; i++) begin
         send_command(directed[i]);
      end
      for (i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 200 && i < 300);
         send_command(random_row());
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      $display("Sent %0d commands (%0d ticks) and checked %0d status words.",
               commands_sent, ticks_sent, words_checked);
      $display("The channel table saw %0d toggles and %0d budget-driven stops.",
               toggles_seen, auto_stops);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
